/* rtl/core/neighborhood_rank_window_select_top_defines.svh */
// assertion macros for the neighborhood rank window select block
`ifndef NEIGHBORHOOD_RANK_WINDOW_SELECT_TOP_DEFINES_SVH
`define NEIGHBORHOOD_RANK_WINDOW_SELECT_TOP_DEFINES_SVH

`ifndef SYNTH

`define NRWS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nrws assertion failed");

`define NRWS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("nrws forbidden condition seen");

`else

`define NRWS_ASSERT(lbl, prop)

`define NRWS_NEVER(lbl, cond)

`endif

`endif

/* rtl/core/nrws_pkg.sv */
// shared constants and types for the neighborhood rank window select block
package nrws_pkg;

    localparam int RANK_W  = 4;
    localparam int COUNT_W = 4;
    localparam int MAX_NB  = 9;

    typedef struct packed {
        logic [RANK_W-1:0] base;
        logic [RANK_W-1:0] last;
    } emit_cfg_t;

endpackage

/* rtl/core/nrws_lane.sv */
// one rank lane: counts how many samples sort ahead of its own sample
module nrws_lane #(
    parameter int NEIGHBORS  = 9,
    parameter int PIXEL_BITS = 16,
    parameter int LANE       = 0
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [PIXEL_BITS-1:0]       vals [NEIGHBORS],
    output logic signed [PIXEL_BITS-1:0]       value_reg,
    output logic [nrws_pkg::RANK_W-1:0]        rank_reg
);
    import nrws_pkg::*;

    logic [RANK_W-1:0] rank_next;

    always_comb
    begin
        rank_next = '0;
        for (int j = 0; j < NEIGHBORS; j++)
        begin
            if (j < LANE)
            begin
                if (vals[j] <= vals[LANE])
                    rank_next = rank_next + RANK_W'(1);
            end
            else if (j > LANE)
            begin
                if (vals[j] < vals[LANE])
                    rank_next = rank_next + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= vals[LANE];
            rank_reg  <= rank_next;
        end
    end

endmodule

/* rtl/core/nrws_merge.sv */
// merge stage: places each lane's sample at the slot given by its rank
module nrws_merge #(
    parameter int NEIGHBORS  = 9,
    parameter int PIXEL_BITS = 16
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [PIXEL_BITS-1:0]       values [NEIGHBORS],
    input  logic [nrws_pkg::RANK_W-1:0]        ranks [NEIGHBORS],
    output logic signed [PIXEL_BITS-1:0]       sorted_reg [NEIGHBORS]
);
    import nrws_pkg::*;

    logic [PIXEL_BITS-1:0] sorted_next [NEIGHBORS];

    always_comb
    begin
        for (int r = 0; r < NEIGHBORS; r++)
        begin
            sorted_next[r] = '0;
            for (int i = 0; i < NEIGHBORS; i++)
            begin
                if (ranks[i] == RANK_W'(r))
                    sorted_next[r] = sorted_next[r] | values[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < NEIGHBORS; r++)
                sorted_reg[r] <= signed'(sorted_next[r]);
        end
    end

endmodule

/* rtl/core/nrws_emit.sv */
// emitter: walks the selected rank window and drives the output register
module nrws_emit #(
    parameter int NEIGHBORS  = 9,
    parameter int PIXEL_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               src_valid,
    input  logic signed [PIXEL_BITS-1:0]       sorted [NEIGHBORS],
    input  nrws_pkg::emit_cfg_t                cfg,
    output logic                               take,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [PIXEL_BITS-1:0]       out_value,
    output logic [nrws_pkg::RANK_W-1:0]        out_rank,
    output logic                               out_last
);
    import nrws_pkg::*;

    localparam int IDX_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;

    logic signed [PIXEL_BITS-1:0] buf_reg [NEIGHBORS];
    logic [RANK_W-1:0]            idx_reg;
    logic [RANK_W-1:0]            last_idx_reg;
    logic                         busy_reg;
    logic                         out_valid_reg;
    logic signed [PIXEL_BITS-1:0] out_value_reg;
    logic [RANK_W-1:0]            out_rank_reg;
    logic                         out_last_reg;
    logic                         load_out;
    logic                         at_last;

    assign load_out = !out_valid_reg || !out_stall;
    assign at_last  = (idx_reg == last_idx_reg);
    assign take     = src_valid && (!busy_reg || (load_out && at_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= busy_reg;
            if (take)
                busy_reg <= 1'b1;
            else if (busy_reg && load_out && at_last)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && load_out)
        begin
            out_value_reg <= buf_reg[idx_reg[IDX_W-1:0]];
            out_rank_reg  <= idx_reg;
            out_last_reg  <= at_last;
        end
        if (take)
        begin
            for (int r = 0; r < NEIGHBORS; r++)
                buf_reg[r] <= sorted[r];
            idx_reg      <= cfg.base;
            last_idx_reg <= cfg.last;
        end
        else if (busy_reg && load_out)
            idx_reg <= idx_reg + RANK_W'(1);
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_rank  = out_rank_reg;
    assign out_last  = out_last_reg;

    `include "neighborhood_rank_window_select_top_defines.svh"

    `NRWS_NEVER(a_idx_in_window, busy_reg && (idx_reg > last_idx_reg))
    `NRWS_ASSERT(a_nonlast_keeps_busy, (busy_reg && load_out && !at_last) |=> busy_reg)
    `NRWS_NEVER(a_rank_bound, out_valid_reg && (out_rank_reg >= RANK_W'(NEIGHBORS)))

endmodule

/* rtl/core/neighborhood_rank_window_select_top.sv */
// top level of the neighborhood rank window select block
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  in       | in_valid / in_stall     | center_value, neighbor_0..8, neighbor_valid,
//           |                         | center_selected
//  out      | out_valid / out_stall   | feature_value, feature_rank, last_feature
//  config   | cfg_we                  | cfg_wdata (feature_count)
//
//  a word passes the substitute, rank lane and merge stage registers to the emitter
//  each pixel yields feature_count words (clamped to 1..NEIGHBORS), one per emitter step,
//  so with a count of 1 one pixel is taken every cycle while the output is not stalled
//  unselected pixels are dropped at the input stage and yield no words
//  output stall backs up through the stage enables to in_stall in the same cycle
//  reset clears stage valids and sets feature_count to 1
module neighborhood_rank_window_select_top #(
    parameter int NEIGHBORS  = 9,
    parameter int PIXEL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [PIXEL_BITS-1:0]  center_value,
    input  logic signed [PIXEL_BITS-1:0]  neighbor_0,
    input  logic signed [PIXEL_BITS-1:0]  neighbor_1,
    input  logic signed [PIXEL_BITS-1:0]  neighbor_2,
    input  logic signed [PIXEL_BITS-1:0]  neighbor_3,
    input  logic signed [PIXEL_BITS-1:0]  neighbor_4,
    input  logic signed [PIXEL_BITS-1:0]  neighbor_5,
    input  logic signed [PIXEL_BITS-1:0]  neighbor_6,
    input  logic signed [PIXEL_BITS-1:0]  neighbor_7,
    input  logic signed [PIXEL_BITS-1:0]  neighbor_8,
    input  logic [nrws_pkg::MAX_NB-1:0]   neighbor_valid,
    input  logic                          center_selected,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [PIXEL_BITS-1:0]  feature_value,
    output logic [nrws_pkg::RANK_W-1:0]   feature_rank,
    output logic                          last_feature,
    input  logic                          cfg_we,
    input  logic [nrws_pkg::COUNT_W-1:0]  cfg_wdata
);
    import nrws_pkg::*;

    logic signed [PIXEL_BITS-1:0] nb_all [MAX_NB];
    logic signed [PIXEL_BITS-1:0] s1_vals_reg [NEIGHBORS];
    logic signed [PIXEL_BITS-1:0] s2_vals [NEIGHBORS];
    logic [RANK_W-1:0]            s2_ranks [NEIGHBORS];
    logic signed [PIXEL_BITS-1:0] s3_sorted [NEIGHBORS];
    logic                         s1_valid_reg;
    logic                         s2_valid_reg;
    logic                         s3_valid_reg;
    logic                         en1;
    logic                         en2;
    logic                         en3;
    logic                         emit_take;
    logic [COUNT_W-1:0]           count_reg;
    logic [COUNT_W-1:0]           count_clamped;
    emit_cfg_t                    emit_cfg;

    assign nb_all[0] = neighbor_0;
    assign nb_all[1] = neighbor_1;
    assign nb_all[2] = neighbor_2;
    assign nb_all[3] = neighbor_3;
    assign nb_all[4] = neighbor_4;
    assign nb_all[5] = neighbor_5;
    assign nb_all[6] = neighbor_6;
    assign nb_all[7] = neighbor_7;
    assign nb_all[8] = neighbor_8;

    assign en3      = !s3_valid_reg || emit_take;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            count_reg    <= COUNT_W'(1);
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid && center_selected;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (cfg_we)
                count_reg <= cfg_wdata;
        end
    end

    // invalid neighbors take the center value
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < NEIGHBORS; i++)
                s1_vals_reg[i] <= neighbor_valid[i] ? nb_all[i] : center_value;
        end
    end

    for (genvar g = 0; g < NEIGHBORS; g++)
    begin : g_lane
        nrws_lane #(
            .NEIGHBORS  (NEIGHBORS),
            .PIXEL_BITS (PIXEL_BITS),
            .LANE       (g)
        ) u_lane (
            .clk       (clk),
            .en        (en2),
            .vals      (s1_vals_reg),
            .value_reg (s2_vals[g]),
            .rank_reg  (s2_ranks[g])
        );
    end

    nrws_merge #(
        .NEIGHBORS  (NEIGHBORS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_merge (
        .clk        (clk),
        .en         (en3),
        .values     (s2_vals),
        .ranks      (s2_ranks),
        .sorted_reg (s3_sorted)
    );

    always_comb
    begin
        priority if (count_reg == '0)
            count_clamped = COUNT_W'(1);
        else if (count_reg > COUNT_W'(NEIGHBORS))
            count_clamped = COUNT_W'(NEIGHBORS);
        else
            count_clamped = count_reg;
        emit_cfg.base = RANK_W'(NEIGHBORS / 2) - RANK_W'(count_clamped >> 1);
        emit_cfg.last = emit_cfg.base + RANK_W'(count_clamped) - RANK_W'(1);
    end

    nrws_emit #(
        .NEIGHBORS  (NEIGHBORS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (s3_valid_reg),
        .sorted    (s3_sorted),
        .cfg       (emit_cfg),
        .take      (emit_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (feature_value),
        .out_rank  (feature_rank),
        .out_last  (last_feature)
    );

endmodule

/* test/tb_top.sv */
// testbench for neighborhood_rank_window_select_top: self-checking window rank predictor
`timescale 1ns / 1ps

module tb_top;

    import nrws_pkg::*;

    localparam int PIX_W = 16;
    localparam int NB = 9;
    localparam int CENTER_RANK = NB / 2;
    localparam int RANDOM_PER_PHASE = 55;
    localparam int PHASES = 8;
    localparam int DIRECTED_AT_RESET = 5;
    localparam int DIRECTED_TOTAL = 20;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [PIX_W-1:0]         center;
        logic [NB-1:0][PIX_W-1:0] nb;
        logic [MAX_NB-1:0]        valid;
        logic                     sel;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0]  value;
        logic [RANK_W-1:0] rank;
        logic              last;
    } feature_t;

    class rank_window_scoreboard;
        int unsigned count_reg;
        feature_t pending_features[$];
        int errors;

        function new();
            count_reg = 1;
            errors = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] v);
            count_reg = v;
        endfunction

        function int pending();
            return pending_features.size();
        endfunction

        function void note_pixel(pixel_t p);
            logic signed [PIX_W-1:0] vals [NB];
            logic signed [PIX_W-1:0] key;
            int j;
            int unsigned n;
            int unsigned base;
            feature_t f;
            if (!p.sel)
                return;
            for (int i = 0; i < NB; i++)
                vals[i] = p.valid[i] ? p.nb[i] : p.center;
            // stable ascending sort, equal values keep neighbor order
            for (int i = 1; i < NB; i++)
            begin
                key = vals[i];
                j = i;
                while (j > 0 && vals[j-1] > key)
                begin
                    vals[j] = vals[j-1];
                    j--;
                end
                vals[j] = key;
            end
            n = count_reg;
            if (n == 0)
                n = 1;
            if (n > NB)
                n = NB;
            base = CENTER_RANK - n / 2;
            for (int unsigned i = 0; i < n; i++)
            begin
                f.value = vals[base + i];
                f.rank = RANK_W'(base + i);
                f.last = (i == n - 1);
                pending_features.insert(pending_features.size(), f);
            end
        endfunction

        function void check_feature(logic [PIX_W-1:0] value, logic [RANK_W-1:0] rank,
                                    logic last);
            feature_t exp_f;
            if (pending_features.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got %0d/%0d/%0d",
                         $time, $signed(value), rank, last);
                errors++;
                return;
            end
            exp_f = pending_features.pop_front();
            if (value !== exp_f.value || rank !== exp_f.rank || last !== exp_f.last)
            begin
                $display("%0t: mismatch, expected %0d/%0d/%0d, got %0d/%0d/%0d",
                         $time, $signed(exp_f.value), exp_f.rank, exp_f.last,
                         $signed(value), rank, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [PIX_W-1:0] center_value;
    logic signed [PIX_W-1:0] neighbor_0;
    logic signed [PIX_W-1:0] neighbor_1;
    logic signed [PIX_W-1:0] neighbor_2;
    logic signed [PIX_W-1:0] neighbor_3;
    logic signed [PIX_W-1:0] neighbor_4;
    logic signed [PIX_W-1:0] neighbor_5;
    logic signed [PIX_W-1:0] neighbor_6;
    logic signed [PIX_W-1:0] neighbor_7;
    logic signed [PIX_W-1:0] neighbor_8;
    logic [MAX_NB-1:0] neighbor_valid;
    logic center_selected;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [PIX_W-1:0] feature_value;
    logic [RANK_W-1:0] feature_rank;
    logic last_feature;
    logic cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    rank_window_scoreboard sb;
    int stall_left = 0;
    int cycle_count = 0;

    neighborhood_rank_window_select_top #(
        .NEIGHBORS (NB),
        .PIXEL_BITS(PIX_W)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .center_value   (center_value),
        .neighbor_0     (neighbor_0),
        .neighbor_1     (neighbor_1),
        .neighbor_2     (neighbor_2),
        .neighbor_3     (neighbor_3),
        .neighbor_4     (neighbor_4),
        .neighbor_5     (neighbor_5),
        .neighbor_6     (neighbor_6),
        .neighbor_7     (neighbor_7),
        .neighbor_8     (neighbor_8),
        .neighbor_valid (neighbor_valid),
        .center_selected(center_selected),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .feature_value  (feature_value),
        .feature_rank   (feature_rank),
        .last_feature   (last_feature),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        sb = new();
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // output side stall, in segments of random length
    always @(negedge clk)
    begin
        int r;
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                out_stall <= 1'b0;
                stall_left = $urandom_range(0, 19);
            end
            else if (r < 85)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else if (r < 95)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(3, 9);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(19, 39);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_feature(feature_value, feature_rank, last_feature);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PIX_W-1:0] rand_sample(int mode);
        case (mode)
            0: return PIX_W'($urandom);
            1: return PIX_W'($urandom_range(0, 4)) - PIX_W'(2);
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'hffff;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int r;
        int mode;
        r = $urandom_range(0, 99);
        mode = (r < 60) ? 0 : (r < 85) ? 1 : 2;
        p.center = rand_sample(mode);
        for (int i = 0; i < NB; i++)
            p.nb[i] = rand_sample(mode);
        r = $urandom_range(0, 99);
        if (r < 70)
            p.valid = MAX_NB'($urandom);
        else if (r < 85)
            p.valid = '1;
        else if (r < 95)
            p.valid = '0;
        else
            p.valid = MAX_NB'(1) << $urandom_range(0, NB - 1);
        p.sel = ($urandom_range(0, 99) < 88);
        return p;
    endfunction

    function automatic pixel_t directed_pixel(int k);
        pixel_t p;
        p = '0;
        p.sel = 1'b1;
        p.valid = '1;
        case (k)
            1:  for (int i = 0; i < NB; i++) p.nb[i] = 16'h7fff;
            2:  for (int i = 0; i < NB; i++) p.nb[i] = 16'h8000;
            3, 5:  for (int i = 0; i < NB; i++) p.nb[i] = PIX_W'(i - CENTER_RANK);
            4, 14:
            begin
                p.sel = 1'b0;
                p.center = 16'h1234;
                for (int i = 0; i < NB; i++) p.nb[i] = PIX_W'(i * 97);
            end
            6:  for (int i = 0; i < NB; i++) p.nb[i] = PIX_W'(CENTER_RANK - i);
            7:  for (int i = 0; i < NB; i++) p.nb[i] = i[0] ? 16'h7fff : 16'h8000;
            8:
            begin
                p.valid = '0;
                p.center = 16'h7fff;
                for (int i = 0; i < NB; i++) p.nb[i] = PIX_W'(i * 1111 - 3000);
            end
            9:
            begin
                p.valid = '0;
                p.center = 16'h8000;
                for (int i = 0; i < NB; i++) p.nb[i] = 16'h7fff;
            end
            10:
            begin
                p.valid = 9'h155;
                for (int i = 0; i < NB; i++) p.nb[i] = i[0] ? 16'h8000 : 16'h7fff;
            end
            11:
            begin
                p.valid = 9'h0aa;
                p.center = 16'h0100;
                for (int i = 0; i < NB; i++) p.nb[i] = PIX_W'(200 - i * 50);
            end
            12:
            begin
                p.center = -16'sd5;
                for (int i = 0; i < NB; i++) p.nb[i] = 16'd5;
            end
            13:
            begin
                p.nb = {16'd2, 16'd2, 16'd2, 16'd1, 16'd3, 16'd1, 16'd3, 16'd1, 16'd3};
            end
            15:
            begin
                p.valid = 9'h100;
                p.center = 16'd1;
                for (int i = 0; i < NB; i++) p.nb[i] = 16'hffff;
            end
            16:
            begin
                p.valid = 9'h001;
                p.center = 16'h7fff;
                p.nb[0] = 16'h8000;
            end
            17:
            begin
                p.nb = {16'h0002, 16'hfffe, 16'hffff, 16'h0001, 16'h0000,
                        16'h8000, 16'h8001, 16'h7ffe, 16'h7fff};
            end
            18:
            begin
                p.valid = 9'h1fe;
                p.center = 16'h8000;
                for (int i = 0; i < NB; i++) p.nb[i] = PIX_W'(i * 4099);
            end
            19:  for (int i = 0; i < NB; i++) p.nb[i] = i[0] ? 16'h5555 : 16'haaaa;
            default: ;
        endcase
        return p;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_pixel(input pixel_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        center_value <= p.center;
        neighbor_0 <= p.nb[0];
        neighbor_1 <= p.nb[1];
        neighbor_2 <= p.nb[2];
        neighbor_3 <= p.nb[3];
        neighbor_4 <= p.nb[4];
        neighbor_5 <= p.nb[5];
        neighbor_6 <= p.nb[6];
        neighbor_7 <= p.nb[7];
        neighbor_8 <= p.nb[8];
        neighbor_valid <= p.valid;
        center_selected <= p.sel;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pixel(p);
        @(negedge clk);
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] v);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_count(v);
    endtask

    function automatic logic [COUNT_W-1:0] phase_count(int ph);
        case (ph)
            1: return COUNT_W'(NB);
            2: return '0;
            3: return '1;
            4: return COUNT_W'(2);
            5: return COUNT_W'(7);
            default: return COUNT_W'($urandom_range(0, 15));
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        center_value = '0;
        neighbor_0 = '0;
        neighbor_1 = '0;
        neighbor_2 = '0;
        neighbor_3 = '0;
        neighbor_4 = '0;
        neighbor_5 = '0;
        neighbor_6 = '0;
        neighbor_7 = '0;
        neighbor_8 = '0;
        neighbor_valid = '0;
        center_selected = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
                write_count(phase_count(ph));
            if (ph == 0)
                for (int k = 0; k < DIRECTED_AT_RESET; k++)
                    send_pixel(directed_pixel(k));
            if (ph == 1)
                for (int k = DIRECTED_AT_RESET; k < DIRECTED_TOTAL; k++)
                    send_pixel(directed_pixel(k));
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_pixel(random_pixel());
            in_valid <= 1'b0;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
